/* src/assert_macros.svh */
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMP(lbl, ante, cons)
`define AST_NXT(lbl, ante, cons)
`endif
`endif

/* src/slnu_pkg.sv */
`default_nettype none
package slnu_pkg;
    localparam int W = 32;
    localparam int F = 16;
    localparam int CW = 31;
    localparam int SAT_IN = 66;
    localparam logic [30:0] ROOT2_Q30 = 31'd1518500250;

    localparam logic [2:0] REG_K = 3'd0;
    localparam logic [2:0] REG_NU = 3'd1;
    localparam logic [2:0] REG_D = 3'd2;
    localparam logic [2:0] REG_SOM = 3'd3;
    localparam logic [2:0] REG_TS = 3'd4;

    typedef struct packed {
        logic load;
        logic diff;
        logic square;
        logic sqrt_init;
        logic sqrt_step;
        logic ext;
        logic mul;
        logic div_init;
        logic div_step;
        logic spring;
        logic acc;
        logic vel_mul;
        logic vel_add;
        logic pos_mul;
        logic pos_add;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic clip;
        logic signed [W-1:0] val;
    } t_sat;

    localparam logic signed [SAT_IN-1:0] SAT_MAX = {{(SAT_IN-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SAT_IN-1:0] SAT_MIN = ~SAT_MAX;

    function automatic t_sat sat_w(input logic signed [SAT_IN-1:0] v);
        t_sat r;
        if (v > SAT_MAX) begin
            r.clip = 1'b1;
            r.val = SAT_MAX[W-1:0];
        end else if (v < SAT_MIN) begin
            r.clip = 1'b1;
            r.val = SAT_MIN[W-1:0];
        end else begin
            r.clip = 1'b0;
            r.val = v[W-1:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* src/slnu_ctrl.sv */
`default_nettype none
module slnu_ctrl import slnu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_SQI  = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_EXT  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DVI  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_SPR  = 4'd9;
    localparam logic [3:0] S_ACC  = 4'd10;
    localparam logic [3:0] S_VM   = 4'd11;
    localparam logic [3:0] S_VA   = 4'd12;
    localparam logic [3:0] S_PM   = 4'd13;
    localparam logic [3:0] S_PA   = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state = S_SQI;
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_EXT;
                end
            end
            S_EXT: begin
                o_cmd.ext = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DVI;
            end
            S_DVI: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_SPR;
                end
            end
            S_SPR: begin
                o_cmd.spring = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_sts.last ? S_VM : S_IDLE;
            end
            S_VM: begin
                o_cmd.vel_mul = 1'b1;
                n_state = S_VA;
            end
            S_VA: begin
                o_cmd.vel_add = 1'b1;
                n_state = S_PM;
            end
            S_PM: begin
                o_cmd.pos_mul = 1'b1;
                n_state = S_PA;
            end
            S_PA: begin
                o_cmd.pos_add = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

`include "assert_macros.svh"
    `AST_NXT(a_load_diff, r_state == S_IDLE && i_in_valid, r_state == S_DIFF)
    `AST_IMP(a_cnt_rest, !(r_state == S_SQRT || r_state == S_DIV), r_cnt == 5'd0)
    `AST_NXT(a_emit_idle, o_cmd.emit, r_state == S_IDLE)
endmodule
`default_nettype wire

/* src/slnu_dpath.sv */
`default_nettype none
module slnu_dpath import slnu_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_idx,
    input  wire logic [CW-1:0]   i_cfg_data,
    input  wire logic [8*W-1:0]  i_data,
    input  wire logic            i_diag,
    input  wire logic            i_last,
    input  wire t_cmd            i_cmd,
    output t_sts                 o_sts,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [4*W-1:0]       o_data,
    output logic                 o_sat
);
    logic [CW-1:0] r_k, r_nu, r_d, r_som, r_ts;
    logic signed [W-1:0] r_hx, r_hy, r_hvx, r_hvy;
    logic signed [W-1:0] r_nx, r_ny, r_nvx, r_nvy;
    logic r_diag, r_last, r_open, r_clip;
    logic [CW-1:0] r_kk, r_nn;
    logic [61:0] r_dprod;
    logic [W-1:0] r_drest;
    logic signed [W-1:0] r_dx, r_dy, r_dvx, r_dvy;
    logic [63:0] r_sqx, r_sqy;
    logic signed [63:0] r_dmpx, r_dmpy;
    logic [63:0] r_sv, r_res, r_bit;
    logic signed [W-1:0] r_ext, r_dmx, r_dmy;
    logic signed [63:0] r_mx, r_my;
    logic [W-1:0] r_rx, r_ry, r_lx, r_ly, r_qx, r_qy;
    logic r_sgx, r_sgy;
    logic signed [64:0] r_spx, r_spy;
    logic signed [W-1:0] r_fx, r_fy;
    logic signed [63:0] r_vpx, r_vpy, r_ppx, r_ppy;
    logic signed [W-1:0] r_vx, r_vy, r_px, r_py;
    logic signed [W-1:0] r_ox, r_oy, r_ovx, r_ovy;
    logic r_osat, r_ovalid;

    logic [W-1:0] len;
    logic len_nz;
    logic [61:0] dround;
    t_sat s_dx, s_dy, s_dvx, s_dvy, s_ext, s_dmx, s_dmy, s_spx, s_spy, s_fx, s_fy;
    t_sat s_vx, s_vy, s_px, s_py;
    logic [63:0] sq_try;
    logic [63:0] absx, absy;
    logic [W:0] tx, ty;
    logic signed [W:0] qsx, qsy;

    assign len = r_res[W-1:0];
    assign len_nz = (len != '0);
    assign dround = r_dprod + 62'(64'd1 << 29);
    assign sq_try = r_res + r_bit;
    assign absx = r_mx[63] ? 64'(-r_mx) : 64'(r_mx);
    assign absy = r_my[63] ? 64'(-r_my) : 64'(r_my);
    assign tx = {r_rx, r_lx[W-1]};
    assign ty = {r_ry, r_ly[W-1]};
    assign qsx = r_sgx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
    assign qsy = r_sgy ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});

    always_comb begin
        s_dx = sat_w(SAT_IN'(r_nx) - SAT_IN'(r_hx));
        s_dy = sat_w(SAT_IN'(r_ny) - SAT_IN'(r_hy));
        s_dvx = sat_w(SAT_IN'(r_nvx) - SAT_IN'(r_hvx));
        s_dvy = sat_w(SAT_IN'(r_nvy) - SAT_IN'(r_hvy));
        s_ext = sat_w($signed({{(SAT_IN-W){1'b0}}, len}) -
                      $signed({{(SAT_IN-W){1'b0}}, r_drest}));
        s_dmx = sat_w(SAT_IN'(r_dmpx >>> F));
        s_dmy = sat_w(SAT_IN'(r_dmpy >>> F));
        s_spx = sat_w(SAT_IN'(r_spx >>> F));
        s_spy = sat_w(SAT_IN'(r_spy >>> F));
        if (!len_nz) begin
            s_spx = '0;
            s_spy = '0;
        end
        s_fx = sat_w(SAT_IN'(r_fx) + SAT_IN'(s_spx.val) + SAT_IN'(r_dmx));
        s_fy = sat_w(SAT_IN'(r_fy) + SAT_IN'(s_spy.val) + SAT_IN'(r_dmy));
        s_vx = sat_w(SAT_IN'(r_hvx) + SAT_IN'(r_vpx >>> F));
        s_vy = sat_w(SAT_IN'(r_hvy) + SAT_IN'(r_vpy >>> F));
        s_px = sat_w(SAT_IN'(r_hx) + SAT_IN'(r_ppx >>> F));
        s_py = sat_w(SAT_IN'(r_hy) + SAT_IN'(r_ppy >>> F));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= CW'(65536);
            r_nu <= CW'(6554);
            r_d <= CW'(65536);
            r_som <= CW'(655);
            r_ts <= CW'(655);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_K:   r_k <= i_cfg_data;
                REG_NU:  r_nu <= i_cfg_data;
                REG_D:   r_d <= i_cfg_data;
                REG_SOM: r_som <= i_cfg_data;
                REG_TS:  r_ts <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_clip <= 1'b0;
            r_fx <= '0;
            r_fy <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load && !r_open) begin
                r_open <= 1'b1;
                r_clip <= 1'b0;
                r_fx <= '0;
                r_fy <= '0;
            end
            if (i_cmd.diff) begin
                r_clip <= r_clip | s_dx.clip | s_dy.clip | s_dvx.clip | s_dvy.clip;
            end
            if (i_cmd.ext) begin
                r_clip <= r_clip | (len_nz & s_ext.clip) | s_dmx.clip | s_dmy.clip;
            end
            if (i_cmd.acc) begin
                r_clip <= r_clip | s_spx.clip | s_spy.clip | s_fx.clip | s_fy.clip;
                r_fx <= s_fx.val;
                r_fy <= s_fy.val;
            end
            if (i_cmd.vel_add) begin
                r_clip <= r_clip | s_vx.clip | s_vy.clip;
            end
            if (i_cmd.pos_add) begin
                r_clip <= r_clip | s_px.clip | s_py.clip;
            end
            if (i_cmd.emit) begin
                r_open <= 1'b0;
                r_clip <= 1'b0;
                r_fx <= '0;
                r_fy <= '0;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!r_open) begin
                r_hx <= i_data[W-1:0];
                r_hy <= i_data[2*W-1:W];
                r_hvx <= i_data[3*W-1:2*W];
                r_hvy <= i_data[4*W-1:3*W];
            end
            r_nx <= i_data[5*W-1:4*W];
            r_ny <= i_data[6*W-1:5*W];
            r_nvx <= i_data[7*W-1:6*W];
            r_nvy <= i_data[8*W-1:7*W];
            r_diag <= i_diag;
            r_last <= i_last;
            r_kk <= i_diag ? (r_k >> 1) : r_k;
            r_nn <= i_diag ? (r_nu >> 1) : r_nu;
            r_dprod <= r_d * ROOT2_Q30;
        end
        if (i_cmd.diff) begin
            r_dx <= s_dx.val;
            r_dy <= s_dy.val;
            r_dvx <= s_dvx.val;
            r_dvy <= s_dvy.val;
            r_drest <= r_diag ? dround[61:30] : {1'b0, r_d};
        end
        if (i_cmd.square) begin
            r_sqx <= 64'(r_dx * r_dx);
            r_sqy <= 64'(r_dy * r_dy);
            r_dmpx <= 64'($signed({1'b0, r_nn}) * r_dvx);
            r_dmpy <= 64'($signed({1'b0, r_nn}) * r_dvy);
        end
        if (i_cmd.sqrt_init) begin
            r_sv <= r_sqx + r_sqy;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end
        if (i_cmd.sqrt_step) begin
            if (r_sv >= sq_try) begin
                r_sv <= r_sv - sq_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.ext) begin
            r_ext <= s_ext.val;
            r_dmx <= s_dmx.val;
            r_dmy <= s_dmy.val;
        end
        if (i_cmd.mul) begin
            r_mx <= 64'(r_ext * r_dx);
            r_my <= 64'(r_ext * r_dy);
        end
        if (i_cmd.div_init) begin
            r_rx <= absx[63:32];
            r_lx <= absx[31:0];
            r_ry <= absy[63:32];
            r_ly <= absy[31:0];
            r_sgx <= r_mx[63];
            r_sgy <= r_my[63];
            r_qx <= '0;
            r_qy <= '0;
        end
        if (i_cmd.div_step) begin
            if (tx >= {1'b0, len}) begin
                r_rx <= W'(tx - {1'b0, len});
                r_qx <= {r_qx[W-2:0], 1'b1};
            end else begin
                r_rx <= tx[W-1:0];
                r_qx <= {r_qx[W-2:0], 1'b0};
            end
            if (ty >= {1'b0, len}) begin
                r_ry <= W'(ty - {1'b0, len});
                r_qy <= {r_qy[W-2:0], 1'b1};
            end else begin
                r_ry <= ty[W-1:0];
                r_qy <= {r_qy[W-2:0], 1'b0};
            end
            r_lx <= {r_lx[W-2:0], 1'b0};
            r_ly <= {r_ly[W-2:0], 1'b0};
        end
        if (i_cmd.spring) begin
            r_spx <= 65'($signed({1'b0, r_kk}) * qsx);
            r_spy <= 65'($signed({1'b0, r_kk}) * qsy);
        end
        if (i_cmd.vel_mul) begin
            r_vpx <= 64'(r_fx * $signed({1'b0, r_som}));
            r_vpy <= 64'(r_fy * $signed({1'b0, r_som}));
        end
        if (i_cmd.vel_add) begin
            r_vx <= s_vx.val;
            r_vy <= s_vy.val;
        end
        if (i_cmd.pos_mul) begin
            r_ppx <= 64'(r_vx * $signed({1'b0, r_ts}));
            r_ppy <= 64'(r_vy * $signed({1'b0, r_ts}));
        end
        if (i_cmd.pos_add) begin
            r_px <= s_px.val;
            r_py <= s_py.val;
        end
        if (i_cmd.emit) begin
            r_ox <= r_px;
            r_oy <= r_py;
            r_ovx <= r_vx;
            r_ovy <= r_vy;
            r_osat <= r_clip;
        end
    end

    assign o_sts.last = r_last;
    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_data = {r_ovy, r_ovx, r_oy, r_ox};
    assign o_sat = r_osat;
endmodule
`default_nettype wire

/* src/spring_lattice_node_update.sv */
// spring lattice node update
// input stream: one item per neighbour link of a node; tlast marks the last
// neighbour and tuser flags a diagonal link. the own state in the first item
// of a group is held for the whole group.
// each item runs a 32-step bit-pair square root for the link length and a
// 32-step restoring divider (x and y lanes in parallel) for the direction
// ratio. an item is taken only while the sequencer is idle.
// the last item of a group adds the euler step and then one
// result item appears on the output stream, carrying the new position and
// velocity and, in tuser, a flag for any clipping during the group.
// the result sits in an output register: the next item is taken while it
// waits; a stalled receiver only holds the next group's final step.
// configuration writes take effect at once and are meant for idle periods.
// reset (synchronous, active low) restores the default registers, closes
// any open group and drops a pending result.
`default_nettype none
module spring_lattice_node_update import slnu_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_idx,
    input  wire logic [CW-1:0]   i_cfg_data,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    // own_x, own_y, own_vx, own_vy, neighbour_x, neighbour_y, neighbour_vx, neighbour_vy
    input  wire logic [8*W-1:0]  s_axis_tdata,
    input  wire logic            s_axis_tlast,
    // diagonal
    input  wire logic            s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    // new_x, new_y, new_vx, new_vy
    output logic [4*W-1:0]       m_axis_tdata,
    // saturated
    output logic                 m_axis_tuser
);
    t_cmd cmd;
    t_sts sts;

    slnu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    slnu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_data      (s_axis_tdata),
        .i_diag      (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_data      (m_axis_tdata),
        .o_sat       (m_axis_tuser)
    );
endmodule
`default_nettype wire

/* sim/tb_spring_lattice_node_update.sv */
`default_nettype none
module tb_spring_lattice_node_update;
    import slnu_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        sat;
    } t_node_state;

    class node_scoreboard;
        longint unsigned cfg_val[5];
        longint force_x, force_y, pos_x, pos_y, vel_x, vel_y;
        bit group_open, clipped;
        t_node_state pending_q[$];
        int mismatches;

        function new();
            mismatches = 0;
            reset_state();
        endfunction

        function void reset_state();
            cfg_val[REG_K] = 65536;
            cfg_val[REG_NU] = 6554;
            cfg_val[REG_D] = 65536;
            cfg_val[REG_SOM] = 655;
            cfg_val[REG_TS] = 655;
            force_x = 0; force_y = 0;
            group_open = 0; clipped = 0;
        endfunction

        function void write_cfg(int idx, longint unsigned val);
            cfg_val[idx] = val & 64'h7fff_ffff;
        endfunction

        function longint clamp(longint v);
            longint hi, lo;
            hi = 64'sh7fff_ffff;
            lo = -hi - 1;
            if (v > hi) begin
                clipped = 1;
                return hi;
            end
            if (v < lo) begin
                clipped = 1;
                return lo;
            end
            return v;
        endfunction

        function longint mulq(longint a, longint b);
            return (a * b) >>> F;
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function longint field(logic [255:0] d, int i);
            return longint'($signed(d[i*32 +: 32]));
        endfunction

        function void note_item(logic [255:0] d, bit diag, bit last);
            longint k, nu, rest, dx, dy, dvx, dvy, len, sx, sy, ext, vx, vy;
            longint unsigned sq;
            t_node_state r;
            k = longint'(cfg_val[REG_K]);
            nu = longint'(cfg_val[REG_NU]);
            rest = longint'(cfg_val[REG_D]);
            sx = 0; sy = 0;
            if (!group_open) begin
                pos_x = field(d, 0); pos_y = field(d, 1);
                vel_x = field(d, 2); vel_y = field(d, 3);
                force_x = 0; force_y = 0;
                clipped = 0;
                group_open = 1;
            end
            if (diag) begin
                k = k >>> 1;
                nu = nu >>> 1;
                rest = (rest * longint'(ROOT2_Q30) + (64'sd1 << 29)) >>> 30;
            end
            dx = clamp(field(d, 4) - pos_x);
            dy = clamp(field(d, 5) - pos_y);
            dvx = clamp(field(d, 6) - vel_x);
            dvy = clamp(field(d, 7) - vel_y);
            sq = longint'(dx * dx) + longint'(dy * dy);
            len = longint'(int_root(sq));
            if (len > 0) begin
                ext = clamp(len - rest);
                sx = clamp(mulq(k, (ext * dx) / len));
                sy = clamp(mulq(k, (ext * dy) / len));
            end
            force_x = clamp(force_x + sx + clamp(mulq(nu, dvx)));
            force_y = clamp(force_y + sy + clamp(mulq(nu, dvy)));
            if (!last) return;
            vx = clamp(vel_x + mulq(force_x, longint'(cfg_val[REG_SOM])));
            vy = clamp(vel_y + mulq(force_y, longint'(cfg_val[REG_SOM])));
            r.x = clamp(pos_x + mulq(vx, longint'(cfg_val[REG_TS])));
            r.y = clamp(pos_y + mulq(vy, longint'(cfg_val[REG_TS])));
            r.vx = vx;
            r.vy = vy;
            r.sat = clipped;
            pending_q = {pending_q, r};
            group_open = 0;
            force_x = 0; force_y = 0;
            clipped = 0;
        endfunction

        function void check_result(logic [127:0] d, logic s);
            t_node_state e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", d);
                return;
            end
            e = pending_q.pop_front();
            if (d !== {e.vy, e.vx, e.y, e.x} || s !== e.sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("node mismatch: exp x %h y %h vx %h vy %h sat %b, got %h %b",
                             e.x, e.y, e.vx, e.vy, e.sat, d, s);
            end
        endfunction
    endclass

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_cfg_we = 0;
    logic [2:0]    i_cfg_idx = '0;
    logic [CW-1:0] i_cfg_data = '0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    logic [8*W-1:0] s_axis_tdata = '0;
    logic          s_axis_tlast = 0;
    logic          s_axis_tuser = 0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    logic [4*W-1:0] m_axis_tdata;
    logic          m_axis_tuser;

    node_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    spring_lattice_node_update dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    task automatic write_regs(longint unsigned k, longint unsigned nu, longint unsigned d,
                              longint unsigned som, longint unsigned ts);
        longint unsigned vals[5];
        vals = '{k, nu, d, som, ts};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= 3'(i);
            i_cfg_data <= vals[i][CW-1:0];
            sb.write_cfg(i, vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    // valid stays up after an accept until the next item or the idle drop
    task automatic send_item(logic [255:0] d, bit diag, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        s_axis_tuser <= diag;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(d, diag, last);
    endtask

    function automatic logic [31:0] near(logic [31:0] base, int span);
        return base + 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    // lattice-like group: neighbours within about one spacing, small velocities; wild groups and some items are random
    task automatic run_group(int n, bit wild);
        logic [31:0] ox, oy, ovx, ovy;
        logic [255:0] d;
        bit diag;
        ox = $urandom_range(2097152) - 1048576;
        oy = $urandom_range(2097152) - 1048576;
        ovx = $urandom_range(131072) - 65536;
        ovy = $urandom_range(131072) - 65536;
        for (int i = 0; i < n; i++) begin
            diag = $urandom_range(1);
            if (wild || $urandom_range(9) == 0) begin
                d = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            end else begin
                d = {near(ovy, 65536), near(ovx, 65536),
                     near(oy + 32'($signed($urandom_range(2)) - 1) * 65536, 20000),
                     near(ox + 32'($signed($urandom_range(2)) - 1) * 65536, 20000),
                     near(ovy, 3000), near(ovx, 3000), oy, ox};
                if ($urandom_range(3) == 0)
                    d = {$urandom, $urandom, $urandom, $urandom, d[127:0]};
            end
            send_item(d, diag, i == n - 1);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MINN = 32'h8000_0000;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        write_regs(65536, 6554, 65536, 655, 655);
        // zero length link, then clipped differences, then single-item groups
        send_item({32'd5, 32'd7, 32'd65536, 32'd0, 32'd7, 32'd5, 32'd65536, 32'd0}, 0, 0);
        send_item({32'd9, 32'd9, 32'd131072, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0}, 1, 1);
        send_item({MAXP, MAXP, MAXP, MAXP, MINN, MINN, MINN, MINN}, 0, 0);
        send_item({MINN, MINN, MINN, MINN, 32'd0, 32'd0, 32'd0, 32'd0}, 1, 1);
        send_item({MINN, MINN, MINN, MINN, MAXP, MAXP, MAXP, MAXP}, 1, 1);
        send_item({32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0}, 0, 1);
        send_item({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                   32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 0, 1);
        for (int i = 0; i < 4; i++) run_group(i + 1, 0);
        settle();
        write_regs(MAXP, MAXP, MAXP, MAXP, MAXP);
        for (int i = 0; i < 3; i++) run_group(4, i == 2);
        settle();
        write_regs(0, 0, 0, 0, 0);
        for (int i = 0; i < 3; i++) run_group(3, i == 2);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            int sent;
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 13 : 59) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 13 : 59) : 0;
            case (ph)
                0: write_regs(65536, 6554, 65536, 655, 655);
                1: write_regs($urandom_range(262144), $urandom_range(65536),
                              $urandom_range(131072), $urandom_range(65536),
                              $urandom_range(65536));
                2: write_regs($urandom & MAXP, $urandom & MAXP, $urandom & MAXP,
                              $urandom & MAXP, $urandom & MAXP);
                default: write_regs(131072, 13107, 65536, 6554, 6554);
            endcase
            sent = 0;
            while (sent < 380) begin
                int n;
                n = $urandom_range(8, 1);
                run_group(n, $urandom_range(9) == 0);
                sent += n;
            end
            settle();
        end

        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
